[hdl/lse_pkg.sv]
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types, register codes and bit helpers for the LSB stego block.
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned LenW    = 16;
  localparam int unsigned BpbW    = 4;
  localparam int unsigned EmbCntW = LenW + 3;

  typedef enum logic [1:0] {
    RegMode   = 2'd0,
    RegBpb    = 2'd1,
    RegMsgLen = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic            mode;
    logic [BpbW-1:0] bpb;
    logic [LenW-1:0] msg_len;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             is_message;
    logic             underrun;
    logic             last;
  } result_t;

  // bits_per_byte 0 acts as 1, above 8 acts as 8
  function automatic logic [3:0] width_n(input logic [BpbW-1:0] bpb);
    logic [3:0] n;
    if (bpb == 4'd0) begin
      n = 4'd1;
    end else if (bpb > 4'd8) begin
      n = 4'd8;
    end else begin
      n = bpb;
    end
    return n;
  endfunction

  function automatic logic [7:0] low_mask8(input logic [3:0] k);
    logic [8:0] m;
    m = (9'd1 << k) - 9'd1;
    return m[7:0];
  endfunction

  function automatic logic [15:0] low_mask16(input logic [4:0] k);
    logic [16:0] m;
    m = (17'd1 << k) - 17'd1;
    return m[15:0];
  endfunction

endpackage

[hdl/lse_in_if.sv]
// ----------------------------------------------------------------------------
// lse_in_if
// Input channel: carrier or message word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lse_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data;

  modport source (output valid, output action, output data, input ready);
  modport sink   (input valid, input action, input data, output ready);
endinterface

[hdl/lse_out_if.sv]
// ----------------------------------------------------------------------------
// lse_out_if
// Result channel: carrier or recovered message word with flags.
// ----------------------------------------------------------------------------
interface lse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value;
  logic       is_message;
  logic       underrun;
  logic       last;

  modport source (output valid, output value, output is_message, output underrun,
                  output last, input ready);
  modport sink   (input valid, input value, input is_message, input underrun,
                  input last, output ready);
endinterface

[hdl/lsb_stego_embed_extract_top.sv]
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract_top
// LSB steganography: embed message bits into carrier bytes or extract them.
//
//   port        dir   protocol       content
//   in_word_i   in    valid/ready    action, data (carrier or message word)
//   out_word_o  out   valid/ready    value, is_message, underrun, last
//   p*          in    APB            mode @0x0, bits_per_byte @0x4, length @0x8
//
// One word per cycle sustained while out_word_o does not stall; the input register
// and the result register lie between acceptance and result, and state is
// updated in the single pass between them.
// A stall on out_word_o holds the result register and then the input register.
// Reset and any register write clear all message state.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  lse_in_if.sink                    in_word_i,
  lse_out_if.source                 out_word_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lse_pkg::AddrW-1:0] paddr,
  input  logic [lse_pkg::DataW-1:0] pwdata,
  output logic [lse_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  lse_pkg::cfg_t    cfg;
  logic             clear;
  logic             slot_ready;
  logic             res_vld;
  lse_pkg::result_t res;

  lse_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .clear_o (clear)
  );

  lse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .clear_i      (clear),
    .in_word      (in_word_i),
    .slot_ready_i (slot_ready),
    .res_vld_o    (res_vld),
    .res_o        (res)
  );

  lse_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_vld_i    (res_vld),
    .res_i        (res),
    .slot_ready_o (slot_ready),
    .out_word     (out_word_o)
  );

endmodule

[hdl/lse_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lse_cfg_regs
// APB register file: mode, bits per byte, message length; write clears state.
// ----------------------------------------------------------------------------
module lse_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lse_pkg::AddrW-1:0] paddr,
  input  logic [lse_pkg::DataW-1:0] pwdata,
  output logic [lse_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output lse_pkg::cfg_t             cfg_o,
  output logic                      clear_o
);

  lse_pkg::cfg_t    cfg_q, cfg_d;
  logic             wr_en;
  logic             hit;
  lse_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = lse_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b0;
    case (idx)
      lse_pkg::RegMode: begin
        cfg_d.mode = pwdata[0];
        hit        = 1'b1;
      end
      lse_pkg::RegBpb: begin
        cfg_d.bpb = pwdata[lse_pkg::BpbW-1:0];
        hit       = 1'b1;
      end
      lse_pkg::RegMsgLen: begin
        cfg_d.msg_len = pwdata[lse_pkg::LenW-1:0];
        hit           = 1'b1;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    prdata = '0;
    case (idx)
      lse_pkg::RegMode:   prdata = {31'd0, cfg_q.mode};
      lse_pkg::RegBpb:    prdata = {28'd0, cfg_q.bpb};
      lse_pkg::RegMsgLen: prdata = {16'd0, cfg_q.msg_len};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: 1'b0, bpb: 4'd1, msg_len: 16'd0};
    end else if (wr_en && hit) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o   = cfg_q;
  assign clear_o = wr_en && hit;

endmodule

[hdl/lse_core.sv]
// ----------------------------------------------------------------------------
// lse_core
// Input register, embed/extract state and single-pass bit packing logic.
// ----------------------------------------------------------------------------
module lse_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lse_pkg::cfg_t      cfg_i,
  input  logic               clear_i,
  lse_in_if.sink             in_word,
  input  logic               slot_ready_i,
  output logic               res_vld_o,
  output lse_pkg::result_t   res_o
);

  logic       in_vld_q;
  logic       in_action_q;
  logic [7:0] in_data_q;
  logic       advance;

  logic [15:0]                   pend_q, pend_d;
  logic [4:0]                    pcnt_q, pcnt_d;
  logic [lse_pkg::EmbCntW-1:0]   emb_q, emb_d;
  logic [7:0]                    gb_q, gb_d;
  logic [2:0]                    gc_q, gc_d;
  logic [lse_pkg::LenW-1:0]      ext_q, ext_d;

  assign advance       = in_vld_q && slot_ready_i;
  assign in_word.ready = !in_vld_q || advance;

  // hold the accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_word.ready) begin
      in_vld_q <= in_word.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_word.ready && in_word.valid) begin
      in_action_q <= in_word.action;
      in_data_q   <= in_word.data;
    end
  end

  always_comb begin
    logic [3:0]                  n;
    logic [7:0]                  nmask;
    logic [lse_pkg::EmbCntW-1:0] total;
    logic [lse_pkg::EmbCntW-1:0] left;
    logic [3:0]                  k;
    logic [4:0]                  shamt;
    logic [15:0]                 shifted;
    logic [7:0]                  bits;
    logic [7:0]                  placed;
    logic [lse_pkg::EmbCntW-1:0] emb_nx;
    logic [15:0]                 comb;
    logic [3:0]                  cnt;
    logic [2:0]                  rem;
    logic [15:0]                 comb_sh;
    logic [lse_pkg::LenW-1:0]    ext_nx;

    n       = lse_pkg::width_n(cfg_i.bpb);
    nmask   = lse_pkg::low_mask8(n);
    total   = {cfg_i.msg_len, 3'b000};
    left    = total - emb_q;
    k       = (left < lse_pkg::EmbCntW'(n)) ? left[3:0] : n;
    shamt   = pcnt_q - {1'b0, k};
    shifted = pend_q >> shamt;
    bits    = shifted[7:0] & lse_pkg::low_mask8(k);
    placed  = 8'(bits << (n - k));
    emb_nx  = emb_q + lse_pkg::EmbCntW'(k);
    comb    = ({8'd0, gb_q} << n) | {8'd0, in_data_q & nmask};
    cnt     = {1'b0, gc_q} + n;
    rem     = cnt[2:0];
    comb_sh = comb >> rem;
    ext_nx  = ext_q + 16'd1;

    pend_d = pend_q;
    pcnt_d = pcnt_q;
    emb_d  = emb_q;
    gb_d   = gb_q;
    gc_d   = gc_q;
    ext_d  = ext_q;

    res_vld_o        = 1'b0;
    res_o.value      = in_data_q;
    res_o.is_message = 1'b0;
    res_o.underrun   = 1'b0;
    res_o.last       = 1'b0;

    if (!cfg_i.mode) begin
      if (in_action_q) begin
        if (pcnt_q <= 5'd8) begin
          pend_d = {pend_q[7:0], in_data_q};
          pcnt_d = pcnt_q + 5'd8;
        end
      end else begin
        res_vld_o = 1'b1;
        if (emb_q < total) begin
          if (pcnt_q < {1'b0, k}) begin
            res_o.underrun = 1'b1;
          end else begin
            pcnt_d      = shamt;
            pend_d      = pend_q & lse_pkg::low_mask16(shamt);
            res_o.value = (in_data_q & ~nmask) | placed;
            emb_d       = emb_nx;
            res_o.last  = (emb_nx == total);
          end
        end
      end
    end else if (!in_action_q && (ext_q < cfg_i.msg_len)) begin
      if (cnt < 4'd8) begin
        gb_d = comb[7:0];
        gc_d = cnt[2:0];
      end else begin
        res_vld_o        = 1'b1;
        res_o.value      = comb_sh[7:0];
        res_o.is_message = 1'b1;
        gc_d             = rem;
        gb_d             = comb[7:0] & lse_pkg::low_mask8({1'b0, rem});
        ext_d            = ext_nx;
        if (ext_nx == cfg_i.msg_len) begin
          res_o.last = 1'b1;
          gb_d       = 8'd0;
          gc_d       = 3'd0;
        end
      end
    end

    if (!advance) begin
      res_vld_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pcnt_q <= '0;
      emb_q  <= '0;
      gb_q   <= '0;
      gc_q   <= '0;
      ext_q  <= '0;
    end else if (clear_i) begin
      pend_q <= '0;
      pcnt_q <= '0;
      emb_q  <= '0;
      gb_q   <= '0;
      gc_q   <= '0;
      ext_q  <= '0;
    end else if (advance) begin
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
      emb_q  <= emb_d;
      gb_q   <= gb_d;
      gc_q   <= gc_d;
      ext_q  <= ext_d;
    end
  end

endmodule

[hdl/lse_out_reg.sv]
// ----------------------------------------------------------------------------
// lse_out_reg
// Result register between the core and the result channel.
// ----------------------------------------------------------------------------
module lse_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_vld_i,
  input  lse_pkg::result_t res_i,
  output logic             slot_ready_o,
  lse_out_if.source        out_word
);

  logic             out_vld_q;
  lse_pkg::result_t res_q;

  assign slot_ready_o = !out_vld_q || out_word.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (slot_ready_o) begin
      out_vld_q <= res_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_ready_o && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_word.valid      = out_vld_q;
  assign out_word.value      = res_q.value;
  assign out_word.is_message = res_q.is_message;
  assign out_word.underrun   = res_q.underrun;
  assign out_word.last       = res_q.last;

endmodule

[verif/lsb_stego_embed_extract_top_tb.sv]
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract_top_tb
// Drives carrier and message words through the LSB stego block, in embed and
// extract mode, across many register settings. Every result word is checked
// field by field against a cycle-free model of the bit buffer and byte gatherer,
// or against the expected word where the plan gives one. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract_top_tb;

  localparam logic ActCarrier  = 1'b0;
  localparam logic ActMessage  = 1'b1;
  localparam logic ModeEmbed   = 1'b0;
  localparam logic ModeExtract = 1'b1;

  typedef enum logic {RowWord, RowReg} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    lse_pkg::reg_idx_e  idx;
    logic               action;
    logic [15:0]        data;
    logic               known;
    lse_pkg::result_t   want;
  } stim_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [lse_pkg::AddrW-1:0] paddr;
  logic [lse_pkg::DataW-1:0] pwdata;
  logic [lse_pkg::DataW-1:0] prdata;
  logic                      pready;

  lse_in_if  in_w ();
  lse_out_if out_w ();

  lsb_stego_embed_extract_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_w),
    .out_word_o (out_w),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // register copy and message state of the model
  logic        cfg_mode;
  logic [3:0]  cfg_bpb;
  logic [15:0] cfg_len;
  logic [15:0] pend_bits;
  logic [4:0]  pend_cnt;
  logic [18:0] emb_bits;
  logic [7:0]  gath_byte;
  logic [2:0]  gath_cnt;
  logic [15:0] ext_cnt;

  lse_pkg::result_t due_words[$];
  stim_row_t        plan[$];
  int unsigned      mismatches;
  int unsigned      sent_words;
  int unsigned      gap_pct;
  int unsigned      stall_pct;
  bit               hold_once;
  logic             cur_known;
  lse_pkg::result_t cur_want;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int unsigned field_width(input logic [3:0] bpb);
    if (bpb == 4'd0) return 1;
    if (bpb > 4'd8) return 8;
    return 32'(bpb);
  endfunction

  function automatic int unsigned ones(input int unsigned k);
    return (32'd1 << k) - 32'd1;
  endfunction

  // advance the model by one word; returns 1 when a result word follows
  function automatic bit stego_step(input logic act, input logic [7:0] dat,
                                    output lse_pkg::result_t res);
    int unsigned n, total, left, k, bits, comb, cnt;
    n = field_width(cfg_bpb);
    res.value      = dat;
    res.is_message = 1'b0;
    res.underrun   = 1'b0;
    res.last       = 1'b0;
    if (cfg_mode == ModeEmbed) begin
      if (act == ActMessage) begin
        if (pend_cnt <= 5'd8) begin
          pend_bits = {pend_bits[7:0], dat};
          pend_cnt  = pend_cnt + 5'd8;
        end
        return 1'b0;
      end
      total = 32'(cfg_len);
      total = total * 8;
      if (emb_bits < total) begin
        left = total - emb_bits;
        k = (left < n) ? left : n;
        if (pend_cnt < k) begin
          res.underrun = 1'b1;
        end else begin
          bits      = (pend_bits >> (pend_cnt - k)) & ones(k);
          pend_cnt  = 5'(pend_cnt - k);
          pend_bits = 16'(pend_bits & ones(pend_cnt));
          res.value = 8'((dat & ~ones(n)) | (bits << (n - k)));
          emb_bits  = 19'(emb_bits + k);
          res.last  = (emb_bits == total);
        end
      end
      return 1'b1;
    end
    if (act == ActMessage || ext_cnt >= cfg_len) return 1'b0;
    comb = 32'(gath_byte);
    comb = (comb << n) | (dat & ones(n));
    cnt  = gath_cnt + n;
    if (cnt < 8) begin
      gath_byte = 8'(comb);
      gath_cnt  = 3'(cnt);
      return 1'b0;
    end
    res.value      = 8'(comb >> (cnt - 8));
    gath_cnt       = 3'(cnt - 8);
    gath_byte      = 8'(comb & ones(cnt - 8));
    res.is_message = 1'b1;
    ext_cnt        = ext_cnt + 16'd1;
    if (ext_cnt == cfg_len) begin
      res.last  = 1'b1;
      gath_byte = '0;
      gath_cnt  = '0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : check_words
    lse_pkg::result_t want;
    if (rst_ni) begin
      if (out_w.valid && out_w.ready) begin
        if (due_words.size() == 0) begin
          $error("result word with nothing expected: value %0h", out_w.value);
          mismatches++;
        end else begin
          want = due_words.pop_front();
          if (out_w.value !== want.value) begin
            $error("value: expected %0h, got %0h", want.value, out_w.value);
            mismatches++;
          end
          if (out_w.is_message !== want.is_message) begin
            $error("is_message: expected %0b, got %0b", want.is_message, out_w.is_message);
            mismatches++;
          end
          if (out_w.underrun !== want.underrun) begin
            $error("underrun: expected %0b, got %0b", want.underrun, out_w.underrun);
            mismatches++;
          end
          if (out_w.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_w.last);
            mismatches++;
          end
        end
      end
      if (in_w.valid && in_w.ready) begin
        if (stego_step(in_w.action, in_w.data, want)) begin
          due_words.push_back(cur_known ? cur_want : want);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_w.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_word(input logic act, input logic [7:0] dat, input logic known,
                           input lse_pkg::result_t want);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_w.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_w.valid  <= 1'b1;
    in_w.action <= act;
    in_w.data   <= dat;
    cur_known   <= known;
    cur_want    <= want;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
  endtask

  // hold input until every result word is out and the pipe is empty
  task automatic drain();
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input lse_pkg::reg_idx_e idx,
                           input logic [lse_pkg::DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lse_pkg::RegMode:   cfg_mode = val[0];
      lse_pkg::RegBpb:    cfg_bpb  = val[3:0];
      lse_pkg::RegMsgLen: cfg_len  = val[15:0];
      default: ;
    endcase
    pend_bits = '0;
    pend_cnt  = '0;
    emb_bits  = '0;
    gath_byte = '0;
    gath_cnt  = '0;
    ext_cnt   = '0;
  endtask

  function automatic stim_row_t car(input logic [7:0] d);
    stim_row_t r;
    r = '0;
    r.kind   = RowWord;
    r.action = ActCarrier;
    r.data   = {8'd0, d};
    return r;
  endfunction

  function automatic stim_row_t msg(input logic [7:0] d);
    stim_row_t r;
    r = car(d);
    r.action = ActMessage;
    return r;
  endfunction

  function automatic stim_row_t car_k(input logic [7:0] d, input lse_pkg::result_t want);
    stim_row_t r;
    r = car(d);
    r.known = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input lse_pkg::reg_idx_e idx,
                                        input logic [15:0] val);
    stim_row_t r;
    r = '0;
    r.kind = RowReg;
    r.idx  = idx;
    r.data = val;
    return r;
  endfunction

  task automatic run_phase(input logic mode, input logic [3:0] bpb, input logic [15:0] len,
                           input int unsigned cap);
    int unsigned n, need, queued, c, bits;
    logic act;
    drain();
    write_reg(lse_pkg::RegMode, {31'd0, mode});
    write_reg(lse_pkg::RegBpb, {28'd0, bpb});
    write_reg(lse_pkg::RegMsgLen, {16'd0, len});
    n = field_width(bpb);
    bits = 32'(len);
    need = (bits * 8 + n - 1) / n + $urandom_range(0, 3);
    if (need > cap) need = cap;
    queued = 0;
    c = 0;
    while (c < need) begin
      if (mode == ModeEmbed) begin
        act = (queued < n) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 11) == 0);
      end else begin
        act = ($urandom_range(0, 19) == 0);
      end
      send_word(act, 8'($urandom_range(0, 255)), 1'b0, '0);
      if (act == ActMessage) begin
        if (queued <= 8) queued += 8;
      end else begin
        queued -= (queued < n) ? queued : n;
        c++;
      end
      if (!(mode == ModeExtract && act == ActMessage)) sent_words++;
      if (act == ActCarrier && c == need / 2 && (hold_once || $urandom_range(0, 7) == 0)) begin
        hold_once = 1'b0;
        drain();
      end
    end
  endtask

  initial begin : stimulus
    int unsigned target, pick;
    logic [15:0] len_r;
    rst_ni      <= 1'b0;
    in_w.valid  <= 1'b0;
    in_w.action <= ActCarrier;
    in_w.data   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    cur_known   <= 1'b0;
    cur_want    <= '0;
    cfg_mode    = ModeEmbed;
    cfg_bpb     = 4'd1;
    cfg_len     = '0;
    pend_bits   = '0;
    pend_cnt    = '0;
    emb_bits    = '0;
    gath_byte   = '0;
    gath_cnt    = '0;
    ext_cnt     = '0;
    mismatches  = 0;
    sent_words  = 0;
    hold_once   = 1'b1;
    gap_pct     = 15;
    stall_pct   = 48;

    plan.push_back(car_k(8'hA5, {8'hA5, 1'b0, 1'b0, 1'b0}));
    plan.push_back(reg_row(lse_pkg::RegMsgLen, 16'd1));
    plan.push_back(car_k(8'hFF, {8'hFF, 1'b0, 1'b1, 1'b0}));
    plan.push_back(msg(8'h80));
    plan.push_back(car(8'h00));
    plan.push_back(reg_row(lse_pkg::RegBpb, 16'd8));
    plan.push_back(reg_row(lse_pkg::RegMsgLen, 16'd2));
    plan.push_back(msg(8'h00));
    plan.push_back(msg(8'hFF));
    plan.push_back(msg(8'h5A));
    plan.push_back(car_k(8'hC3, {8'h00, 1'b0, 1'b0, 1'b0}));
    plan.push_back(car_k(8'h3C, {8'hFF, 1'b0, 1'b0, 1'b1}));
    plan.push_back(car_k(8'h77, {8'h77, 1'b0, 1'b0, 1'b0}));
    plan.push_back(reg_row(lse_pkg::RegBpb, 16'd3));
    plan.push_back(reg_row(lse_pkg::RegMsgLen, 16'd1));
    plan.push_back(msg(8'hB7));
    plan.push_back(car(8'hFF));
    plan.push_back(car(8'hFF));
    plan.push_back(car(8'hFF));
    plan.push_back(reg_row(lse_pkg::RegMode, 16'(ModeExtract)));
    plan.push_back(reg_row(lse_pkg::RegMsgLen, 16'd1));
    plan.push_back(msg(8'h12));
    plan.push_back(car(8'h07));
    plan.push_back(car(8'h00));
    plan.push_back(car(8'h05));
    plan.push_back(car(8'hFF));
    plan.push_back(reg_row(lse_pkg::RegBpb, 16'd15));
    plan.push_back(reg_row(lse_pkg::RegMsgLen, 16'd0));
    plan.push_back(car(8'h55));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowReg) begin
        drain();
        write_reg(plan[i].idx, {16'd0, plan[i].data});
      end else begin
        send_word(plan[i].action, plan[i].data[7:0], plan[i].known, plan[i].want);
      end
    end

    run_phase(ModeEmbed, 4'd8, 16'hFFFF, 40);
    run_phase(ModeExtract, 4'd15, 16'hFFFF, 40);

    for (int r = 0; r < 3; r++) begin
      gap_pct   = (r == 0) ? 15 : (r == 1) ? 48 : 0;
      stall_pct = (r == 0) ? 48 : (r == 1) ? 15 : 0;
      target = sent_words + 490;
      while (sent_words < target) begin
        pick = $urandom_range(0, 9);
        len_r = (pick == 0) ? 16'd0 :
                (pick == 1) ? 16'($urandom_range(7, 24)) : 16'($urandom_range(1, 6));
        run_phase(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), len_r, 1000);
      end
    end

    drain();
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
